FILE: hw/rtl/clx_pkg.sv
`default_nettype none

package clx_pkg;

    localparam int BOX_W      = 24;
    localparam int GRID_CFG_W = 5;
    localparam int CELL_IN_W  = 4;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 24;
    localparam int STATUS_W   = 2;

    // register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_CELLS     = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BOX_LENGTH     = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SUM_RADII_MODE = 4'd2;

    localparam logic [GRID_CFG_W-1:0] GRID_CELLS_RST = 5'd16;
    localparam logic [BOX_W-1:0]      BOX_LENGTH_RST = 24'hFF_FFFF;

    localparam logic [STATUS_W-1:0] ST_STORED  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_OVERLAP = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_CELL,
        S_COUNT,
        S_LOAD,
        S_SQX,
        S_SQY,
        S_SQZ,
        S_SQB,
        S_CMP,
        S_NEXT,
        S_HOME,
        S_INSERT
    } t_state;

    typedef enum logic [1:0] {
        OFF_NEG,
        OFF_ZERO,
        OFF_POS
    } t_off;

    typedef enum logic [1:0] {
        SH_NONE,
        SH_UP,
        SH_DOWN
    } t_shift;

    typedef enum logic [1:0] {
        SQ_X,
        SQ_Y,
        SQ_Z,
        SQ_B
    } t_sq_sel;

    typedef struct packed {
        logic    load;
        logic    mul;
        t_sq_sel sel;
    } t_dist_ctl;

endpackage

`default_nettype wire

FILE: hw/rtl/cell_list_exclusion_check.sv
// Scan: an accepted start walks the 27 neighbour cells and compares each stored sphere
//   found there on the one squarer; an overlap ends the scan early, else the candidate is
//   appended to its home cell list if there is room, and the o_valid strobe follows.
//   One word in flight: o_busy high until o_valid, so no new word is taken mid-scan.
// Reset: counts cleared by a sweep over all GRID_MAX^3 cells (4096 by default), o_busy high
//   meanwhile; configuration writes taken throughout. Results cannot be stalled.
`default_nettype none

module cell_list_exclusion_check #(
    parameter int GRID_MAX     = 16,
    parameter int MAX_PER_CELL = 8,
    parameter int COORD_BITS   = 24
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_start,
    output logic                                  o_busy,
    input  wire logic [COORD_BITS-1:0]            i_cand_x,
    input  wire logic [COORD_BITS-1:0]            i_cand_y,
    input  wire logic [COORD_BITS-1:0]            i_cand_z,
    input  wire logic [COORD_BITS-1:0]            i_cand_radius,
    input  wire logic [clx_pkg::CELL_IN_W-1:0]    i_cell_i,
    input  wire logic [clx_pkg::CELL_IN_W-1:0]    i_cell_j,
    input  wire logic [clx_pkg::CELL_IN_W-1:0]    i_cell_k,
    output logic                                  o_valid,
    output logic [clx_pkg::STATUS_W-1:0]          o_status,
    input  wire logic                             i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  wire logic [clx_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [clx_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    localparam int NUM_CELLS = GRID_MAX * GRID_MAX * GRID_MAX;
    localparam int NUM_SLOTS = NUM_CELLS * MAX_PER_CELL;
    localparam int CAW       = $clog2(NUM_CELLS);
    localparam int SAW       = $clog2(NUM_SLOTS);
    localparam int IW        = $clog2(GRID_MAX);
    localparam int GW        = $clog2(GRID_MAX + 1);
    localparam int NW        = $clog2(MAX_PER_CELL + 1);
    localparam int WIDE      = (COORD_BITS > clx_pkg::BOX_W) ? COORD_BITS : clx_pkg::BOX_W;
    localparam int POS_W     = WIDE + 2;
    localparam int WORD_W    = 4 * COORD_BITS;

    clx_pkg::t_state r_state, n_state;

    logic [clx_pkg::GRID_CFG_W-1:0] r_grid_cells;
    logic [clx_pkg::BOX_W-1:0]      r_box_length;
    logic                           r_sum_mode;

    logic [COORD_BITS-1:0]   r_x, r_y, r_z, r_rad;
    logic [IW-1:0]           r_hi, r_hj, r_hk;
    logic [GW-1:0]           r_g;
    clx_pkg::t_off           r_oa, r_ob, r_oc;
    logic [CAW-1:0]          r_cell;
    logic signed [POS_W-1:0] r_px, r_py, r_pz;
    logic [NW-1:0]           r_n, r_s;
    logic [CAW-1:0]          r_clr;
    logic                    r_valid, n_valid;
    logic [clx_pkg::STATUS_W-1:0] r_status, n_status;

    logic [GW-1:0]      w_g;
    logic [IW-1:0]      w_ni, w_nj, w_nk;
    logic [CAW-1:0]     w_nb_cell, w_home_cell;
    logic [NW-1:0]      w_s_inc;
    logic               w_last;
    logic               w_hit;

    logic               w_cnt_we;
    logic [CAW-1:0]     w_cnt_waddr, w_cnt_raddr;
    logic [NW-1:0]      w_cnt_wdata, w_cnt_rd;
    logic               w_dat_we;
    logic [SAW-1:0]     w_dat_waddr, w_dat_raddr;
    logic [WORD_W-1:0]  w_dat_wdata, w_dat_rd;
    clx_pkg::t_dist_ctl w_ctl;

    function automatic logic [IW-1:0] sat_home(
        input logic [clx_pkg::CELL_IN_W-1:0] h,
        input logic [GW-1:0]                 g
    );
        if (32'(h) >= 32'(g)) begin
            sat_home = IW'(32'(g) - 1);
        end else begin
            sat_home = IW'(h);
        end
    endfunction

    function automatic logic [IW-1:0] wrap_idx(
        input logic [IW-1:0] h,
        input clx_pkg::t_off off,
        input logic [GW-1:0] g
    );
        case (off)
            clx_pkg::OFF_NEG: wrap_idx = (h == '0) ? IW'(32'(g) - 1) : h - IW'(1);
            clx_pkg::OFF_POS: wrap_idx = (32'(h) + 1 >= 32'(g)) ? '0 : h + IW'(1);
            default:          wrap_idx = h;
        endcase
    endfunction

    function automatic clx_pkg::t_shift wrap_shift(
        input logic [IW-1:0] h,
        input clx_pkg::t_off off,
        input logic [GW-1:0] g
    );
        case (off)
            clx_pkg::OFF_NEG: wrap_shift = (h == '0) ? clx_pkg::SH_UP : clx_pkg::SH_NONE;
            clx_pkg::OFF_POS: wrap_shift = (32'(h) + 1 >= 32'(g)) ? clx_pkg::SH_DOWN
                                                                 : clx_pkg::SH_NONE;
            default:          wrap_shift = clx_pkg::SH_NONE;
        endcase
    endfunction

    function automatic logic signed [POS_W-1:0] shift_pos(
        input logic [COORD_BITS-1:0]    c,
        input clx_pkg::t_shift          sh,
        input logic [clx_pkg::BOX_W-1:0] len
    );
        logic signed [POS_W-1:0] b;
        logic signed [POS_W-1:0] l;
        b = $signed({{(POS_W-COORD_BITS){1'b0}}, c});
        l = $signed({{(POS_W-clx_pkg::BOX_W){1'b0}}, len});
        case (sh)
            clx_pkg::SH_UP:   shift_pos = b + l;
            clx_pkg::SH_DOWN: shift_pos = b - l;
            default:          shift_pos = b;
        endcase
    endfunction

    function automatic logic [CAW-1:0] cell_addr(
        input logic [IW-1:0] i,
        input logic [IW-1:0] j,
        input logic [IW-1:0] k
    );
        cell_addr = CAW'((32'(i) * GRID_MAX + 32'(j)) * GRID_MAX + 32'(k));
    endfunction

    function automatic logic [SAW-1:0] slot_addr(
        input logic [CAW-1:0] cidx,
        input logic [NW-1:0]  s
    );
        slot_addr = SAW'(32'(cidx) * MAX_PER_CELL + 32'(s));
    endfunction

    function automatic clx_pkg::t_off off_inc(input clx_pkg::t_off o);
        case (o)
            clx_pkg::OFF_NEG:  off_inc = clx_pkg::OFF_ZERO;
            clx_pkg::OFF_ZERO: off_inc = clx_pkg::OFF_POS;
            default:           off_inc = clx_pkg::OFF_NEG;
        endcase
    endfunction

    // grid size in use: zero acts as one, capped at GRID_MAX
    always_comb begin
        if (r_grid_cells == '0) begin
            w_g = GW'(1);
        end else if (32'(r_grid_cells) > GRID_MAX) begin
            w_g = GW'(GRID_MAX);
        end else begin
            w_g = GW'(r_grid_cells);
        end
    end

    assign w_ni        = wrap_idx(r_hi, r_oa, r_g);
    assign w_nj        = wrap_idx(r_hj, r_ob, r_g);
    assign w_nk        = wrap_idx(r_hk, r_oc, r_g);
    assign w_nb_cell   = cell_addr(w_ni, w_nj, w_nk);
    assign w_home_cell = cell_addr(r_hi, r_hj, r_hk);
    assign w_s_inc     = r_s + NW'(1);
    assign w_last      = (r_oa == clx_pkg::OFF_POS) && (r_ob == clx_pkg::OFF_POS)
                      && (r_oc == clx_pkg::OFF_POS);
    assign w_dat_wdata = {r_x, r_y, r_z, r_rad};

    clx_ram #(
        .WIDTH (NW),
        .DEPTH (NUM_CELLS)
    ) u_count_ram (
        .i_clk   (i_clk),
        .i_we    (w_cnt_we),
        .i_waddr (w_cnt_waddr),
        .i_wdata (w_cnt_wdata),
        .i_raddr (w_cnt_raddr),
        .o_rdata (w_cnt_rd)
    );

    clx_ram #(
        .WIDTH (WORD_W),
        .DEPTH (NUM_SLOTS)
    ) u_sphere_ram (
        .i_clk   (i_clk),
        .i_we    (w_dat_we),
        .i_waddr (w_dat_waddr),
        .i_wdata (w_dat_wdata),
        .i_raddr (w_dat_raddr),
        .o_rdata (w_dat_rd)
    );

    clx_dist #(
        .COORD_BITS (COORD_BITS)
    ) u_dist (
        .i_clk      (i_clk),
        .i_ctl      (w_ctl),
        .i_px       (r_px),
        .i_py       (r_py),
        .i_pz       (r_pz),
        .i_sphere   (w_dat_rd),
        .i_rad      (r_rad),
        .i_sum_mode (r_sum_mode),
        .o_hit      (w_hit)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            clx_pkg::S_CLEAR: begin
                if (r_clr == CAW'(NUM_CELLS - 1)) begin
                    n_state = clx_pkg::S_IDLE;
                end
            end
            clx_pkg::S_IDLE: begin
                if (i_start) begin
                    n_state = clx_pkg::S_CELL;
                end
            end
            clx_pkg::S_CELL:  n_state = clx_pkg::S_COUNT;
            clx_pkg::S_COUNT: n_state = (w_cnt_rd == '0) ? clx_pkg::S_NEXT : clx_pkg::S_LOAD;
            clx_pkg::S_LOAD:  n_state = clx_pkg::S_SQX;
            clx_pkg::S_SQX:   n_state = clx_pkg::S_SQY;
            clx_pkg::S_SQY:   n_state = clx_pkg::S_SQZ;
            clx_pkg::S_SQZ:   n_state = clx_pkg::S_SQB;
            clx_pkg::S_SQB:   n_state = clx_pkg::S_CMP;
            clx_pkg::S_CMP: begin
                if (w_hit) begin
                    n_state = clx_pkg::S_IDLE;
                end else if (w_s_inc < r_n) begin
                    n_state = clx_pkg::S_LOAD;
                end else begin
                    n_state = clx_pkg::S_NEXT;
                end
            end
            clx_pkg::S_NEXT:   n_state = w_last ? clx_pkg::S_HOME : clx_pkg::S_CELL;
            clx_pkg::S_HOME:   n_state = clx_pkg::S_INSERT;
            clx_pkg::S_INSERT: n_state = clx_pkg::S_IDLE;
            default:           n_state = clx_pkg::S_IDLE;
        endcase
    end

    // outputs and memory controls
    always_comb begin
        w_cnt_we    = 1'b0;
        w_cnt_waddr = w_home_cell;
        w_cnt_wdata = w_cnt_rd + NW'(1);
        w_cnt_raddr = w_nb_cell;
        w_dat_we    = 1'b0;
        w_dat_waddr = slot_addr(w_home_cell, w_cnt_rd);
        w_dat_raddr = slot_addr(r_cell, '0);
        w_ctl       = '{load: 1'b0, mul: 1'b0, sel: clx_pkg::SQ_X};
        n_valid     = 1'b0;
        n_status    = r_status;
        case (r_state)
            clx_pkg::S_CLEAR: begin
                w_cnt_we    = 1'b1;
                w_cnt_waddr = r_clr;
                w_cnt_wdata = '0;
            end
            clx_pkg::S_LOAD: w_ctl.load = 1'b1;
            clx_pkg::S_SQX:  w_ctl = '{load: 1'b0, mul: 1'b1, sel: clx_pkg::SQ_X};
            clx_pkg::S_SQY:  w_ctl = '{load: 1'b0, mul: 1'b1, sel: clx_pkg::SQ_Y};
            clx_pkg::S_SQZ:  w_ctl = '{load: 1'b0, mul: 1'b1, sel: clx_pkg::SQ_Z};
            clx_pkg::S_SQB:  w_ctl = '{load: 1'b0, mul: 1'b1, sel: clx_pkg::SQ_B};
            clx_pkg::S_CMP: begin
                // fetch the next slot while comparing this one
                w_dat_raddr = slot_addr(r_cell, w_s_inc);
                if (w_hit) begin
                    n_valid  = 1'b1;
                    n_status = clx_pkg::ST_OVERLAP;
                end
            end
            clx_pkg::S_HOME: w_cnt_raddr = w_home_cell;
            clx_pkg::S_INSERT: begin
                n_valid = 1'b1;
                if (32'(w_cnt_rd) >= MAX_PER_CELL) begin
                    n_status = clx_pkg::ST_FULL;
                end else begin
                    w_cnt_we = 1'b1;
                    w_dat_we = 1'b1;
                    n_status = clx_pkg::ST_STORED;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= clx_pkg::S_CLEAR;
            r_clr        <= '0;
            r_valid      <= 1'b0;
            r_status     <= clx_pkg::ST_STORED;
            r_grid_cells <= clx_pkg::GRID_CELLS_RST;
            r_box_length <= clx_pkg::BOX_LENGTH_RST;
            r_sum_mode   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_valid  <= n_valid;
            r_status <= n_status;

            if (i_cfg_valid) begin
                case (i_cfg_index)
                    clx_pkg::CFG_GRID_CELLS:
                        r_grid_cells <= i_cfg_data[clx_pkg::GRID_CFG_W-1:0];
                    clx_pkg::CFG_BOX_LENGTH:
                        r_box_length <= i_cfg_data[clx_pkg::BOX_W-1:0];
                    clx_pkg::CFG_SUM_RADII_MODE:
                        r_sum_mode <= i_cfg_data[0];
                    default: ;
                endcase
            end

            case (r_state)
                clx_pkg::S_CLEAR: r_clr <= r_clr + CAW'(1);
                clx_pkg::S_IDLE: begin
                    if (i_start) begin
                        r_x   <= i_cand_x;
                        r_y   <= i_cand_y;
                        r_z   <= i_cand_z;
                        r_rad <= i_cand_radius;
                        r_hi  <= sat_home(i_cell_i, w_g);
                        r_hj  <= sat_home(i_cell_j, w_g);
                        r_hk  <= sat_home(i_cell_k, w_g);
                        r_g   <= w_g;
                        r_oa  <= clx_pkg::OFF_NEG;
                        r_ob  <= clx_pkg::OFF_NEG;
                        r_oc  <= clx_pkg::OFF_NEG;
                    end
                end
                clx_pkg::S_CELL: begin
                    r_cell <= w_nb_cell;
                    r_px   <= shift_pos(r_x, wrap_shift(r_hi, r_oa, r_g), r_box_length);
                    r_py   <= shift_pos(r_y, wrap_shift(r_hj, r_ob, r_g), r_box_length);
                    r_pz   <= shift_pos(r_z, wrap_shift(r_hk, r_oc, r_g), r_box_length);
                end
                clx_pkg::S_COUNT: begin
                    r_n <= w_cnt_rd;
                    r_s <= '0;
                end
                clx_pkg::S_CMP: r_s <= w_s_inc;
                clx_pkg::S_NEXT: begin
                    if (r_oc == clx_pkg::OFF_POS) begin
                        r_oc <= clx_pkg::OFF_NEG;
                        if (r_ob == clx_pkg::OFF_POS) begin
                            r_ob <= clx_pkg::OFF_NEG;
                            r_oa <= off_inc(r_oa);
                        end else begin
                            r_ob <= off_inc(r_ob);
                        end
                    end else begin
                        r_oc <= off_inc(r_oc);
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_busy      = (r_state != clx_pkg::S_IDLE) || !i_rst_n;
    assign o_valid     = r_valid;
    assign o_status    = r_status;
    assign o_cfg_ready = i_rst_n;

    a_start_scans: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> (r_state == clx_pkg::S_CELL))
        else $error("accepted word did not start the neighbour scan");

    a_result_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (r_state == clx_pkg::S_IDLE))
        else $error("result strobe while still scanning");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_status == clx_pkg::ST_STORED || o_status == clx_pkg::ST_OVERLAP
                     || o_status == clx_pkg::ST_FULL))
        else $error("result carries an undefined status");

    a_no_overfill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == clx_pkg::S_INSERT && w_cnt_we) |-> (32'(w_cnt_rd) < MAX_PER_CELL))
        else $error("append into a full cell list");

endmodule

`default_nettype wire

FILE: hw/rtl/clx_ram.sv
`default_nettype none

module clx_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

FILE: hw/rtl/clx_dist.sv
`default_nettype none

// Shared squared-distance unit: one squarer, reused for dx, dy, dz and the bound.
module clx_dist #(
    parameter int COORD_BITS = 24
) (
    input  wire logic                                             i_clk,
    input  wire clx_pkg::t_dist_ctl                               i_ctl,
    input  wire logic signed [((COORD_BITS > clx_pkg::BOX_W) ? COORD_BITS
                               : clx_pkg::BOX_W) + 1:0]           i_px,
    input  wire logic signed [((COORD_BITS > clx_pkg::BOX_W) ? COORD_BITS
                               : clx_pkg::BOX_W) + 1:0]           i_py,
    input  wire logic signed [((COORD_BITS > clx_pkg::BOX_W) ? COORD_BITS
                               : clx_pkg::BOX_W) + 1:0]           i_pz,
    input  wire logic        [4*COORD_BITS-1:0]                   i_sphere,
    input  wire logic        [COORD_BITS-1:0]                     i_rad,
    input  wire logic                                             i_sum_mode,
    output logic                                                  o_hit
);

    localparam int WIDE   = (COORD_BITS > clx_pkg::BOX_W) ? COORD_BITS : clx_pkg::BOX_W;
    localparam int POS_W  = WIDE + 2;
    localparam int DIFF_W = WIDE + 1;
    localparam int SQ_W   = 2 * DIFF_W;
    localparam int ACC_W  = SQ_W + 2;

    logic [DIFF_W-1:0] r_dx, r_dy, r_dz, r_bd;
    logic [SQ_W-1:0]   r_prod;
    logic [ACC_W-1:0]  r_acc;
    logic [DIFF_W-1:0] w_op;
    logic [DIFF_W-1:0] w_bound;

    function automatic logic [DIFF_W-1:0] abs_diff(
        input logic signed [POS_W-1:0] p,
        input logic [COORD_BITS-1:0]   s
    );
        logic signed [POS_W-1:0] d;
        d = p - $signed({{(POS_W-COORD_BITS){1'b0}}, s});
        abs_diff = d[POS_W-1] ? DIFF_W'(-d) : DIFF_W'(d);
    endfunction

    // stored word: x, y, z, radius from the top
    assign w_bound = DIFF_W'(i_sphere[COORD_BITS-1:0])
                   + (i_sum_mode ? DIFF_W'(i_rad) : '0);

    always_comb begin
        case (i_ctl.sel)
            clx_pkg::SQ_X: w_op = r_dx;
            clx_pkg::SQ_Y: w_op = r_dy;
            clx_pkg::SQ_Z: w_op = r_dz;
            default:       w_op = r_bd;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_dx <= abs_diff(i_px, i_sphere[4*COORD_BITS-1:3*COORD_BITS]);
            r_dy <= abs_diff(i_py, i_sphere[3*COORD_BITS-1:2*COORD_BITS]);
            r_dz <= abs_diff(i_pz, i_sphere[2*COORD_BITS-1:COORD_BITS]);
            r_bd <= w_bound;
        end
        if (i_ctl.mul) begin
            r_prod <= {{DIFF_W{1'b0}}, w_op} * {{DIFF_W{1'b0}}, w_op};
            // product lags one step behind the operand select
            if (i_ctl.sel == clx_pkg::SQ_X) begin
                r_acc <= '0;
            end else begin
                r_acc <= r_acc + ACC_W'(r_prod);
            end
        end
    end

    // valid once the bound square sits in r_prod and the three squares in r_acc
    assign o_hit = r_acc < ACC_W'(r_prod);

endmodule

`default_nettype wire

FILE: bench/testbench.sv
`timescale 1ns / 1ps

import clx_pkg::*;

localparam int GRID_SIDE  = 16;
localparam int CELL_DEPTH = 8;
localparam int NUM_CELLS  = GRID_SIDE * GRID_SIDE * GRID_SIDE;
localparam int NUM_SLOTS  = NUM_CELLS * CELL_DEPTH;

typedef struct packed {
    logic [BOX_W-1:0]     x;
    logic [BOX_W-1:0]     y;
    logic [BOX_W-1:0]     z;
    logic [BOX_W-1:0]     radius;
    logic [CELL_IN_W-1:0] ci;
    logic [CELL_IN_W-1:0] cj;
    logic [CELL_IN_W-1:0] ck;
} t_cand;

class exclusion_scoreboard;
    logic [GRID_CFG_W-1:0] grid_cells;
    logic [BOX_W-1:0]      box_len;
    logic                  sum_mode;
    logic [3:0]            cell_fill [NUM_CELLS];
    logic [BOX_W-1:0]      sph_x [NUM_SLOTS];
    logic [BOX_W-1:0]      sph_y [NUM_SLOTS];
    logic [BOX_W-1:0]      sph_z [NUM_SLOTS];
    logic [BOX_W-1:0]      sph_r [NUM_SLOTS];
    logic [STATUS_W-1:0]   status_q [$];
    int                    errors;

    function new();
        grid_cells = GRID_CELLS_RST;
        box_len    = BOX_LENGTH_RST;
        sum_mode   = 1'b0;
        errors     = 0;
        foreach (cell_fill[n]) cell_fill[n] = '0;
    endfunction

    function int grid_in_use();
        if (grid_cells == 0) return 1;
        if (grid_cells > GRID_SIDE) return GRID_SIDE;
        return int'(grid_cells);
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        case (idx)
            CFG_GRID_CELLS:     grid_cells = data[GRID_CFG_W-1:0];
            CFG_BOX_LENGTH:     box_len    = data[BOX_W-1:0];
            CFG_SUM_RADII_MODE: sum_mode   = data[0];
            default: ;
        endcase
    endfunction

    // neighbour index along one axis; shift carries the candidate across the wrap
    function int wrap_index(int h, int off, int g, output longint shift);
        shift = 0;
        if (off < 0) begin
            if (h == 0) begin
                shift = longint'(box_len);
                return g - 1;
            end
            return h - 1;
        end
        if (off > 0) begin
            if (h + 1 >= g) begin
                shift = -longint'(box_len);
                return 0;
            end
            return h + 1;
        end
        return h;
    endfunction

    function bit hits_stored(int cidx, longint px, longint py, longint pz, longint rad);
        int     s;
        int     slot;
        longint dx, dy, dz, bound;
        for (s = 0; s < int'(cell_fill[cidx]) && s < CELL_DEPTH; s++) begin
            slot  = cidx * CELL_DEPTH + s;
            dx    = px - longint'(sph_x[slot]);
            dy    = py - longint'(sph_y[slot]);
            dz    = pz - longint'(sph_z[slot]);
            bound = longint'(sph_r[slot]);
            if (sum_mode) bound = bound + rad;
            // strictly inside only
            if (dx * dx + dy * dy + dz * dz < bound * bound) return 1'b1;
        end
        return 1'b0;
    endfunction

    function void note_cand(t_cand c);
        int     g, hi, hj, hk, ni, nj, nk, home, slot, da, db, dc;
        longint shx, shy, shz;
        bit     hit;
        g   = grid_in_use();
        hi  = (int'(c.ci) >= g) ? g - 1 : int'(c.ci);
        hj  = (int'(c.cj) >= g) ? g - 1 : int'(c.cj);
        hk  = (int'(c.ck) >= g) ? g - 1 : int'(c.ck);
        hit = 1'b0;
        for (da = -1; da <= 1 && !hit; da++) begin
            for (db = -1; db <= 1 && !hit; db++) begin
                for (dc = -1; dc <= 1 && !hit; dc++) begin
                    ni  = wrap_index(hi, da, g, shx);
                    nj  = wrap_index(hj, db, g, shy);
                    nk  = wrap_index(hk, dc, g, shz);
                    hit = hits_stored((ni * GRID_SIDE + nj) * GRID_SIDE + nk,
                                      longint'(c.x) + shx, longint'(c.y) + shy,
                                      longint'(c.z) + shz, longint'(c.radius));
                end
            end
        end
        home = (hi * GRID_SIDE + hj) * GRID_SIDE + hk;
        // an overlap wins over a full list
        if (hit) begin
            status_q.push_back(ST_OVERLAP);
        end else if (cell_fill[home] >= CELL_DEPTH) begin
            status_q.push_back(ST_FULL);
        end else begin
            slot            = home * CELL_DEPTH + int'(cell_fill[home]);
            sph_x[slot]     = c.x;
            sph_y[slot]     = c.y;
            sph_z[slot]     = c.z;
            sph_r[slot]     = c.radius;
            cell_fill[home] = cell_fill[home] + 4'd1;
            status_q.push_back(ST_STORED);
        end
    endfunction

    task report(string msg);
        $display("mismatch: %s", msg);
        errors++;
    endtask

    task check_status(logic [STATUS_W-1:0] got);
        logic [STATUS_W-1:0] want;
        if (status_q.size() == 0) begin
            report($sformatf("status %0d with no word outstanding", got));
            return;
        end
        want = status_q.pop_front();
        if (got !== want) report($sformatf("status %0d, predicted %0d", got, want));
    endtask

    function int pending();
        return status_q.size();
    endfunction
endclass

module testbench;
    localparam int IDLE_LIMIT   = 20000;
    localparam int DRAIN_CYCLES = 1500;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 4'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 4'd15;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_start     = 1'b0;
    logic [BOX_W-1:0]      i_cand_x    = '0;
    logic [BOX_W-1:0]      i_cand_y    = '0;
    logic [BOX_W-1:0]      i_cand_z    = '0;
    logic [BOX_W-1:0]      i_cand_radius = '0;
    logic [CELL_IN_W-1:0]  i_cell_i    = '0;
    logic [CELL_IN_W-1:0]  i_cell_j    = '0;
    logic [CELL_IN_W-1:0]  i_cell_k    = '0;
    logic                  i_cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;
    logic                  o_busy;
    logic                  o_valid;
    logic [STATUS_W-1:0]   o_status;
    logic                  o_cfg_ready;

    exclusion_scoreboard sb;
    int idle_cycles = 0;

    cell_list_exclusion_check u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (i_start),
        .o_busy        (o_busy),
        .i_cand_x      (i_cand_x),
        .i_cand_y      (i_cand_y),
        .i_cand_z      (i_cand_z),
        .i_cand_radius (i_cand_radius),
        .i_cell_i      (i_cell_i),
        .i_cell_j      (i_cell_j),
        .i_cell_k      (i_cell_k),
        .o_valid       (o_valid),
        .o_status      (o_status),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid === 1'b1) sb.check_status(o_status);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_start && !o_busy) || o_valid || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("[cell_list_exclusion_check] ERROR");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = data;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.write_reg(idx, data);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // start dropped, then hold until every word is back and the block is free
    task automatic wait_drain();
        @(negedge i_clk);
        i_start = 1'b0;
        while (sb.pending() != 0 || o_busy) @(negedge i_clk);
    endtask

    task automatic set_config(logic [CFG_DATA_W-1:0] grid, logic [CFG_DATA_W-1:0] box,
                              logic [CFG_DATA_W-1:0] mode);
        wait_drain();
        cfg_write(CFG_GRID_CELLS, grid);
        cfg_write(CFG_BOX_LENGTH, box);
        cfg_write(CFG_SUM_RADII_MODE, mode);
    endtask

    task automatic send_cand(t_cand c, int gap);
        @(negedge i_clk);
        if (gap > 0) begin
            i_start = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_start       = 1'b1;
        i_cand_x      = c.x;
        i_cand_y      = c.y;
        i_cand_z      = c.z;
        i_cand_radius = c.radius;
        i_cell_i      = c.ci;
        i_cell_j      = c.cj;
        i_cell_k      = c.ck;
        do @(posedge i_clk); while (o_busy);
        sb.note_cand(c);
    endtask

    function automatic t_cand mk_cand(logic [BOX_W-1:0] x, logic [BOX_W-1:0] y,
                                      logic [BOX_W-1:0] z, logic [BOX_W-1:0] r,
                                      logic [CELL_IN_W-1:0] ci, logic [CELL_IN_W-1:0] cj,
                                      logic [CELL_IN_W-1:0] ck);
        t_cand c;
        c.x      = x;
        c.y      = y;
        c.z      = z;
        c.radius = r;
        c.ci     = ci;
        c.cj     = cj;
        c.ck     = ck;
        return c;
    endfunction

    // favour the edges of the grid so lists fill and wraps happen
    function automatic logic [CELL_IN_W-1:0] pick_index(int g);
        int r;
        r = $urandom_range(0, 9);
        if (r < 3) return '0;
        if (r < 6) return CELL_IN_W'(g - 1);
        if (r == 6) return CELL_IN_W'($urandom_range(0, 15));
        return CELL_IN_W'($urandom_range(0, g - 1));
    endfunction

    function automatic logic [BOX_W-1:0] coord_in_cell(logic [CELL_IN_W-1:0] idx, int g,
                                                       longint w);
        longint v;
        int     h;
        h = (int'(idx) >= g) ? g - 1 : int'(idx);
        v = longint'(h) * w + longint'($urandom_range(0, int'(w) - 1));
        return v[BOX_W-1:0];
    endfunction

    function automatic t_cand rand_cand();
        t_cand  c;
        int     g;
        int     r;
        longint w;
        if ($urandom_range(0, 99) < 15) begin
            c.x      = BOX_W'($urandom);
            c.y      = BOX_W'($urandom);
            c.z      = BOX_W'($urandom);
            c.radius = ($urandom_range(0, 1) == 0) ? BOX_W'($urandom)
                                                   : BOX_W'($urandom_range(0, 4095));
            c.ci     = CELL_IN_W'($urandom);
            c.cj     = CELL_IN_W'($urandom);
            c.ck     = CELL_IN_W'($urandom);
            return c;
        end
        g = sb.grid_in_use();
        w = longint'(sb.box_len) / g;
        if (w == 0) w = 1;
        c.ci = pick_index(g);
        c.cj = pick_index(g);
        c.ck = pick_index(g);
        c.x  = coord_in_cell(c.ci, g, w);
        c.y  = coord_in_cell(c.cj, g, w);
        c.z  = coord_in_cell(c.ck, g, w);
        r    = $urandom_range(0, 19);
        if (r == 0)      c.radius = '0;
        else if (r == 1) c.radius = BOX_W'($urandom);
        else             c.radius = BOX_W'($urandom_range(0, int'(w / 2)));
        return c;
    endfunction

    task automatic run_phase(logic [CFG_DATA_W-1:0] grid, logic [CFG_DATA_W-1:0] box,
                             logic [CFG_DATA_W-1:0] mode, int idle_pct, int items,
                             int pause_at);
        int n;
        int gap;
        set_config(grid, box, mode);
        for (n = 0; n < items; n++) begin
            if (n == pause_at) wait_drain();
            gap = 0;
            if ($urandom_range(0, 99) < idle_pct) begin
                gap = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 400)
                                                  : $urandom_range(1, 20);
            end
            send_cand(rand_cand(), gap);
        end
    endtask

    initial begin
        int n;
        sb = new();
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // grid of zero acts as one, zero box length, mode with only bit 0 low
        set_config(24'h00_0000, 24'h00_0000, 24'hFF_FFFE);
        send_cand(mk_cand(24'd0, 24'd0, 24'd0, 24'd0, 4'd0, 4'd0, 4'd0), 0);
        send_cand(mk_cand(24'hFF_FFFF, 24'hFF_FFFF, 24'hFF_FFFF, 24'hFF_FFFF,
                          4'hF, 4'hF, 4'hF), 0);
        send_cand(mk_cand(24'd10, 24'd10, 24'd10, 24'd5, 4'd0, 4'd0, 4'd0), 0);

        // four cells, upper data bits masked; wrap up on the low side, down on the high
        set_config(24'hFF_FFE4, 24'd1000, 24'd0);
        send_cand(mk_cand(24'd990, 24'd990, 24'd990, 24'd30, 4'd3, 4'd3, 4'd3), 0);
        send_cand(mk_cand(24'd5, 24'd5, 24'd5, 24'd0, 4'd0, 4'd0, 4'd0), 0);
        send_cand(mk_cand(24'd995, 24'd995, 24'd995, 24'd0, 4'hF, 4'hF, 4'hF), 0);

        // two per side: same cell seen with several shifts; sum of radii
        set_config(24'd2, 24'd1, 24'd3);
        send_cand(mk_cand(24'd0, 24'd0, 24'd0, 24'd1, 4'd1, 4'd1, 4'd1), 0);
        send_cand(mk_cand(24'd1, 24'd1, 24'd1, 24'd0, 4'd0, 4'd1, 4'd0), 0);
        send_cand(mk_cand(24'd1, 24'd0, 24'd1, 24'd1, 4'd1, 4'd0, 4'd0), 0);

        // grid above the maximum; writes to spare indexes change nothing
        set_config(24'd31, BOX_LENGTH_RST, 24'd0);
        cfg_write(CFG_SPARE_LO, 24'd1);
        cfg_write(CFG_SPARE_HI, 24'hFF_FFFF);
        // distance exactly on the bound is not a hit, one step inside is
        send_cand(mk_cand(24'd100, 24'd100, 24'd100, 24'd10, 4'd5, 4'd5, 4'd5), 0);
        send_cand(mk_cand(24'd106, 24'd108, 24'd100, 24'd0, 4'd5, 4'd5, 4'd5), 0);
        send_cand(mk_cand(24'd106, 24'd107, 24'd100, 24'd0, 4'd5, 4'd5, 4'd5), 0);
        // fill one list, overflow it, then send one into it that overlaps a sphere in the next cell
        send_cand(mk_cand(24'd2000000, 24'd2000000, 24'd2000000, 24'd1000,
                          4'd9, 4'd9, 4'd10), 0);
        for (n = 0; n < CELL_DEPTH + 1; n++) begin
            send_cand(mk_cand(24'(8000000 + n * 1000), 24'd8000000, 24'd8000000, 24'd0,
                              4'd9, 4'd9, 4'd9), 0);
        end
        send_cand(mk_cand(24'd2000005, 24'd2000000, 24'd2000000, 24'd0,
                          4'd9, 4'd9, 4'd9), 0);

        run_phase(24'd16, BOX_LENGTH_RST, 24'd0, 0, 280, -1);
        run_phase(24'd3, 24'd30000, 24'd1, 61, 280, 140);
        run_phase(24'd8, 24'($urandom_range(1, 24'hFF_FFFF)), 24'd0, 0, 270, -1);
        run_phase(24'd2, 24'd2000, 24'd1, 34, 270, -1);

        wait_drain();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.pending() != 0) sb.report($sformatf("%0d words never returned", sb.pending()));
        if (sb.errors == 0) begin
            $display("[cell_list_exclusion_check] OK");
        end else begin
            $display("[cell_list_exclusion_check] ERROR");
        end
        $finish;
    end
endmodule
